### rtl/key_event_injector_queue_assert.svh
// Assertion macros for the key event injector queue.
// Each macro checks one clocked implication and is disabled while in reset.
`ifndef KEY_EVENT_INJECTOR_QUEUE_ASSERT_SVH
`define KEY_EVENT_INJECTOR_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define KEIQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("key event injector queue check failed");

// Next-cycle implication.
`define KEIQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("key event injector queue check failed");

`else

`define KEIQ_ASSERT_IMP(lbl, ante, cons)
`define KEIQ_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### rtl/kei_pkg.sv
`default_nettype none

package kei_pkg;

    // Field widths of queue entries.
    localparam int KEY_W      = 8;
    localparam int DLY_W      = 4;
    localparam int PEND_W     = KEY_W + 1;
    localparam int DEFR_W     = KEY_W + DLY_W;
    localparam int RESULT_CAP = 16;
    localparam int CNT_W      = 5;

    // Configuration register indexes.
    localparam logic [1:0] REG_ACTIVATE = 2'd0;
    localparam logic [1:0] REG_SNEAK    = 2'd1;
    localparam logic [1:0] REG_SPRINT   = 2'd2;
    localparam logic [1:0] REG_JUMP     = 2'd3;

    // Scancodes that may take a delayed release.
    localparam logic [KEY_W-1:0] KEY_ACTIVATE = 8'h12;
    localparam logic [KEY_W-1:0] KEY_SNEAK    = 8'h1D;
    localparam logic [KEY_W-1:0] KEY_SPRINT   = 8'h38;
    localparam logic [KEY_W-1:0] KEY_JUMP     = 8'h39;

    typedef enum logic [2:0] {
        F_PRESS   = 3'd0,
        F_RELEASE = 3'd1,
        F_PULSE   = 3'd2,
        F_RESET   = 3'd3,
        F_POLL    = 3'd4,
        F_QUERY   = 3'd5
    } t_func;

    typedef logic [3:0][DLY_W-1:0] t_delays;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic do_press;
        logic do_release;
        logic do_pulse;
        logic rst_start;
        logic rst_step;
        logic pop_start;
        logic pop_rd;
        logic pop_wr;
        logic age_start;
        logic age_rd;
        logic age_wr;
        logic age_done;
        logic query_ld;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_go;
        logic age_go;
        logic scan_last;
        logic out_free;
    } t_sts;

    // Release delay of a key: nonzero only for the four special scancodes.
    function automatic logic [DLY_W-1:0] release_delay(input logic [KEY_W-1:0] key,
                                                       input t_delays dl);
        logic [DLY_W-1:0] d;
        d = '0;
        if (key == KEY_ACTIVATE) d = dl[REG_ACTIVATE];
        if (key == KEY_SNEAK)    d = dl[REG_SNEAK];
        if (key == KEY_SPRINT)   d = dl[REG_SPRINT];
        if (key == KEY_JUMP)     d = dl[REG_JUMP];
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/kei_ram.sv
`default_nettype none

module kei_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/kei_ctrl.sv
`default_nettype none

module kei_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [2:0]    i_func,
    output logic               o_in_stall,
    output kei_pkg::t_cmd      o_cmd,
    input  wire kei_pkg::t_sts i_sts
);

    import kei_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b00000000001,
        S_IDLE    = 11'b00000000010,
        S_PRESS   = 11'b00000000100,
        S_RELEASE = 11'b00000001000,
        S_PULSE   = 11'b00000010000,
        S_SCAN    = 11'b00000100000,
        S_POP_CHK = 11'b00001000000,
        S_POP_WR  = 11'b00010000000,
        S_AGE_CHK = 11'b00100000000,
        S_AGE_WR  = 11'b01000000000,
        S_QUERY   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // State register; the latch memory is cleared first after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencing of commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_func)
                        F_PRESS:   n_state = S_PRESS;
                        F_RELEASE: n_state = S_RELEASE;
                        F_PULSE:   n_state = S_PULSE;
                        F_RESET: begin
                            o_cmd.rst_start = 1'b1;
                            n_state = S_SCAN;
                        end
                        F_POLL: begin
                            o_cmd.pop_start = 1'b1;
                            n_state = S_POP_CHK;
                        end
                        F_QUERY:   n_state = S_QUERY;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_PRESS: begin
                o_cmd.do_press = 1'b1;
                n_state = S_IDLE;
            end
            S_RELEASE: begin
                o_cmd.do_release = 1'b1;
                n_state = S_IDLE;
            end
            S_PULSE: begin
                o_cmd.do_pulse = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.rst_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_IDLE;
                end
            end
            S_POP_CHK: begin
                if (i_sts.pop_go) begin
                    o_cmd.pop_rd = 1'b1;
                    n_state = S_POP_WR;
                end else begin
                    o_cmd.age_start = 1'b1;
                    n_state = S_AGE_CHK;
                end
            end
            S_POP_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.pop_wr = 1'b1;
                    n_state = S_POP_CHK;
                end
            end
            S_AGE_CHK: begin
                if (i_sts.age_go) begin
                    o_cmd.age_rd = 1'b1;
                    n_state = S_AGE_WR;
                end else begin
                    o_cmd.age_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_AGE_WR: begin
                o_cmd.age_wr = 1'b1;
                n_state = S_AGE_CHK;
            end
            S_QUERY: begin
                if (i_sts.out_free) begin
                    o_cmd.query_ld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### rtl/kei_dp.sv
`default_nettype none

module kei_dp #(
    parameter int PENDING_DEPTH  = 16,
    parameter int DEFERRED_DEPTH = 16,
    parameter int KEY_COUNT      = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire kei_pkg::t_cmd               i_cmd,
    output kei_pkg::t_sts                    o_sts,
    input  wire logic [kei_pkg::KEY_W-1:0]   i_key_code,
    input  wire logic [6:0]                  i_room,
    input  wire kei_pkg::t_delays            i_delays,
    input  wire logic                        i_out_stall,
    output logic                             o_out_valid,
    output logic      [kei_pkg::KEY_W-1:0]   o_event_key,
    output logic                             o_event_pressed,
    output logic                             o_last,
    output logic                             o_key_down
);

    import kei_pkg::*;

    localparam int PW = $clog2(PENDING_DEPTH);
    localparam int DW = $clog2(DEFERRED_DEPTH);
    localparam int KW = $clog2(KEY_COUNT);

    // Control state.
    logic [PW-1:0]        r_p_head, n_p_head;
    logic [PW:0]          r_p_cnt,  n_p_cnt;
    logic [DW-1:0]        r_d_head, n_d_head;
    logic [DW:0]          r_d_cnt,  n_d_cnt;
    logic [DW:0]          r_rd,     n_rd;
    logic [DW:0]          r_wr,     n_wr;
    logic [CNT_W-1:0]     r_n,      n_n;
    logic [KW-1:0]        r_scan,   n_scan;
    logic                 r_out_valid, n_out_valid;
    logic                 scan_end;

    // Payload registers.
    logic [KEY_W-1:0]     r_key,    n_key;
    logic [6:0]           r_room,   n_room;
    logic [KEY_W-1:0]     r_ev_key, n_ev_key;
    logic                 r_ev_pressed, n_ev_pressed;
    logic                 r_last,   n_last;
    logic                 r_key_down, n_key_down;

    // Memory ports.
    logic              p_we, p_re, d_we, d_re, l_we, l_re;
    logic [PW-1:0]     p_waddr, p_raddr;
    logic [DW-1:0]     d_waddr, d_raddr;
    logic [KW-1:0]     l_waddr, l_raddr;
    logic [PEND_W-1:0] p_wdata, p_rdata;
    logic [DEFR_W-1:0] d_wdata, d_rdata;
    logic              l_wdata, l_rdata;

    // Circular address helpers.
    function automatic logic [PW-1:0] p_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PW+1)'(PENDING_DEPTH)) s = s - (PW+1)'(PENDING_DEPTH);
        return s[PW-1:0];
    endfunction

    function automatic logic [DW-1:0] d_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (DW+1)'(DEFERRED_DEPTH)) s = s - (DW+1)'(DEFERRED_DEPTH);
        return s[DW-1:0];
    endfunction

    kei_ram #(.WIDTH(PEND_W), .DEPTH(PENDING_DEPTH)) u_pend (
        .i_clk  (i_clk),
        .i_we   (p_we),
        .i_waddr(p_waddr),
        .i_wdata(p_wdata),
        .i_re   (p_re),
        .i_raddr(p_raddr),
        .o_rdata(p_rdata)
    );

    kei_ram #(.WIDTH(DEFR_W), .DEPTH(DEFERRED_DEPTH)) u_defr (
        .i_clk  (i_clk),
        .i_we   (d_we),
        .i_waddr(d_waddr),
        .i_wdata(d_wdata),
        .i_re   (d_re),
        .i_raddr(d_raddr),
        .o_rdata(d_rdata)
    );

    // One latch bit per key, read one key at a time.
    kei_ram #(.WIDTH(1), .DEPTH(KEY_COUNT)) u_latch (
        .i_clk  (i_clk),
        .i_we   (l_we),
        .i_waddr(l_waddr),
        .i_wdata(l_wdata),
        .i_re   (l_re),
        .i_raddr(l_raddr),
        .o_rdata(l_rdata)
    );

    assign scan_end = (r_scan == KW'(KEY_COUNT - 1));

    // Status toward the controller.
    always_comb begin
        o_sts.pop_go    = (r_p_cnt != '0) && ({2'b0, r_n} < r_room)
                          && (r_n < CNT_W'(RESULT_CAP));
        o_sts.age_go    = (r_rd < r_d_cnt);
        o_sts.scan_last = scan_end;
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    // Next-state logic of lists, latches and the output word.
    always_comb begin
        logic              key_ok, key_lat, push_p, push_d, p_full, d_full;
        logic [KW-1:0]     key_idx;
        logic [PEND_W-1:0] push_p_data;
        logic [DEFR_W-1:0] push_d_data;
        logic [DLY_W-1:0]  dly, age_d;

        n_p_head = r_p_head;  n_p_cnt = r_p_cnt;
        n_d_head = r_d_head;  n_d_cnt = r_d_cnt;
        n_rd = r_rd;  n_wr = r_wr;  n_n = r_n;  n_scan = r_scan;
        n_key = r_key;  n_room = r_room;
        n_ev_key = r_ev_key;  n_ev_pressed = r_ev_pressed;
        n_last = r_last;  n_key_down = r_key_down;
        n_out_valid = r_out_valid && i_out_stall;

        // The captured key and its latch bit, read in the capture cycle.
        key_ok  = ({1'b0, r_key} < 9'(KEY_COUNT));
        key_idx = r_key[KW-1:0];
        key_lat = key_ok && l_rdata;
        dly     = release_delay(r_key, i_delays);
        age_d   = d_rdata[DEFR_W-1:KEY_W];

        push_p = 1'b0;  push_p_data = '0;
        push_d = 1'b0;  push_d_data = '0;
        p_we = 1'b0;  p_waddr = '0;  p_wdata = '0;
        d_we = 1'b0;  d_waddr = '0;  d_wdata = '0;
        l_we = 1'b0;  l_waddr = '0;  l_wdata = 1'b0;
        p_re = 1'b0;  p_raddr = r_p_head;
        d_re = 1'b0;  d_raddr = d_add(r_d_head, r_rd[DW-1:0]);
        l_re = 1'b0;  l_raddr = i_key_code[KW-1:0];

        if (i_cmd.capture) begin
            n_key  = i_key_code;
            n_room = i_room;
            l_re   = 1'b1;
        end

        // Clearing pass over the latches after reset.
        if (i_cmd.clr_step) begin
            l_we    = 1'b1;
            l_waddr = r_scan;
            l_wdata = 1'b0;
            n_scan  = r_scan + 1'b1;
        end

        // Press, release and pulse finish the cycle after they are taken.
        if (i_cmd.do_press && key_ok && !key_lat) begin
            push_p = 1'b1;  push_p_data = {1'b1, r_key};
            l_we = 1'b1;  l_waddr = key_idx;  l_wdata = 1'b1;
        end
        if (i_cmd.do_release && key_lat) begin
            if (dly != '0) begin
                push_d = 1'b1;  push_d_data = {dly, r_key};
            end else begin
                push_p = 1'b1;  push_p_data = {1'b0, r_key};
                l_we = 1'b1;  l_waddr = key_idx;  l_wdata = 1'b0;
            end
        end
        if (i_cmd.do_pulse && key_ok) begin
            push_p = 1'b1;  push_p_data = {1'b1, r_key};
            push_d = 1'b1;  push_d_data = {dly, r_key};
            l_we = 1'b1;  l_waddr = key_idx;  l_wdata = 1'b1;
        end

        // Reset sweep: empty both lists, then release every latched key.
        // The latch of the next key is read while the current one is handled.
        if (i_cmd.rst_start) begin
            n_p_cnt = '0;  n_d_cnt = '0;  n_scan = '0;
            l_raddr = '0;
        end
        if (i_cmd.rst_step) begin
            if (l_rdata) begin
                push_p = 1'b1;  push_p_data = {1'b0, KEY_W'(r_scan)};
                l_we = 1'b1;  l_waddr = r_scan;  l_wdata = 1'b0;
            end
            l_re    = 1'b1;
            l_raddr = scan_end ? '0 : r_scan + 1'b1;
            n_scan  = r_scan + 1'b1;
        end

        // Poll: pop one event per pass.
        if (i_cmd.pop_start) n_n = '0;
        if (i_cmd.pop_rd)    p_re = 1'b1;
        if (i_cmd.pop_wr) begin
            n_out_valid  = 1'b1;
            n_ev_key     = p_rdata[KEY_W-1:0];
            n_ev_pressed = p_rdata[KEY_W];
            n_key_down   = 1'b0;
            n_last       = ({2'b0, r_n} + 7'd1 == r_room)
                           || (r_n + 1'b1 == CNT_W'(RESULT_CAP))
                           || (r_p_cnt == (PW+1)'(1));
            if (!p_rdata[KEY_W]) begin
                l_we = 1'b1;  l_waddr = p_rdata[KW-1:0];  l_wdata = 1'b0;
            end
            n_p_head = (r_p_head == PW'(PENDING_DEPTH - 1)) ? '0 : r_p_head + 1'b1;
            n_p_cnt  = r_p_cnt - 1'b1;
            n_n      = r_n + 1'b1;
        end

        // Aging: walk the deferred list and compact it in place.
        if (i_cmd.age_start) begin
            n_rd = '0;  n_wr = '0;
        end
        if (i_cmd.age_rd) d_re = 1'b1;
        if (i_cmd.age_wr) begin
            n_rd = r_rd + 1'b1;
            if (age_d != '0) begin
                d_we = 1'b1;
                d_waddr = d_add(r_d_head, r_wr[DW-1:0]);
                d_wdata = {age_d - 1'b1, d_rdata[KEY_W-1:0]};
                n_wr = r_wr + 1'b1;
            end else if (r_p_cnt != (PW+1)'(PENDING_DEPTH)) begin
                push_p = 1'b1;  push_p_data = {1'b0, d_rdata[KEY_W-1:0]};
            end else begin
                d_we = 1'b1;
                d_waddr = d_add(r_d_head, r_wr[DW-1:0]);
                d_wdata = d_rdata;
                n_wr = r_wr + 1'b1;
            end
        end
        if (i_cmd.age_done) n_d_cnt = r_wr;

        // Query answer from the latch bit read at capture.
        if (i_cmd.query_ld) begin
            n_out_valid  = 1'b1;
            n_ev_key     = r_key;
            n_ev_pressed = 1'b0;
            n_last       = 1'b1;
            n_key_down   = key_ok && l_rdata;
        end

        // Pending push; a full queue drops its oldest word.
        p_full = (r_p_cnt == (PW+1)'(PENDING_DEPTH));
        if (push_p) begin
            p_we    = 1'b1;
            p_wdata = push_p_data;
            if (p_full) begin
                p_waddr  = r_p_head;
                n_p_head = (r_p_head == PW'(PENDING_DEPTH - 1)) ? '0 : r_p_head + 1'b1;
            end else begin
                p_waddr = p_add(r_p_head, r_p_cnt[PW-1:0]);
                n_p_cnt = r_p_cnt + 1'b1;
            end
        end

        // Deferred push; a full list drops its oldest word.
        d_full = (r_d_cnt == (DW+1)'(DEFERRED_DEPTH));
        if (push_d) begin
            d_we    = 1'b1;
            d_wdata = push_d_data;
            if (d_full) begin
                d_waddr  = r_d_head;
                n_d_head = (r_d_head == DW'(DEFERRED_DEPTH - 1)) ? '0 : r_d_head + 1'b1;
            end else begin
                d_waddr = d_add(r_d_head, r_d_cnt[DW-1:0]);
                n_d_cnt = r_d_cnt + 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_head <= '0;  r_p_cnt <= '0;
            r_d_head <= '0;  r_d_cnt <= '0;
            r_rd <= '0;  r_wr <= '0;  r_n <= '0;  r_scan <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_p_head <= n_p_head;  r_p_cnt <= n_p_cnt;
            r_d_head <= n_d_head;  r_d_cnt <= n_d_cnt;
            r_rd <= n_rd;  r_wr <= n_wr;  r_n <= n_n;  r_scan <= n_scan;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_key <= n_key;  r_room <= n_room;
        r_ev_key <= n_ev_key;  r_ev_pressed <= n_ev_pressed;
        r_last <= n_last;  r_key_down <= n_key_down;
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_key     = r_ev_key;
    assign o_event_pressed = r_ev_pressed;
    assign o_last          = r_last;
    assign o_key_down      = r_key_down;

endmodule

`default_nettype wire

### rtl/key_event_injector_queue.sv
`default_nettype none

// Key event injector queue. After reset the key latch memory is cleared, one key
// per cycle, so no word is taken until the clearing is done. Press, release and
// pulse words each first read the key's latch and then update it and the lists.
// A query reads the key's latch and then loads its answer once the output stall
// allows. A reset word sweeps every key latch, one key per cycle. A poll delivers
// each event with one read of the pending memory and one load of the output
// register, which waits on the output stall, and then ages the deferred list one
// entry at a time, reading each entry and then writing it back or moving it to the
// pending list. One word is worked on at a time, and the next is taken once the
// last one's work is done.
module key_event_injector_queue #(
    parameter int PENDING_DEPTH  = 16,
    parameter int DEFERRED_DEPTH = 16,
    parameter int KEY_COUNT      = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input word channel.
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_func,
    input  wire logic [7:0]  i_key_code,
    input  wire logic [6:0]  i_room,
    // Result word channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [7:0]  o_event_key,
    output logic             o_event_pressed,
    output logic             o_last,
    output logic             o_key_down,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    import kei_pkg::*;

    localparam logic [DLY_W-1:0] RST_ACTIVATE = 4'd2;
    localparam logic [DLY_W-1:0] RST_SNEAK    = 4'd1;
    localparam logic [DLY_W-1:0] RST_SPRINT   = 4'd4;
    localparam logic [DLY_W-1:0] RST_JUMP     = 4'd1;

    t_delays r_delays;
    t_cmd    cmd;
    t_sts    sts;
    logic    cfg_wr;

    // Delay registers behind the configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delays[REG_ACTIVATE] <= RST_ACTIVATE;
            r_delays[REG_SNEAK]    <= RST_SNEAK;
            r_delays[REG_SPRINT]   <= RST_SPRINT;
            r_delays[REG_JUMP]     <= RST_JUMP;
        end else if (cfg_wr) begin
            r_delays[paddr[3:2]] <= pwdata[DLY_W-1:0];
        end
    end

    assign prdata = {28'd0, r_delays[paddr[3:2]]};

    kei_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_func    (i_func),
        .o_in_stall(o_in_stall),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    kei_dp #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .DEFERRED_DEPTH(DEFERRED_DEPTH),
        .KEY_COUNT     (KEY_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_key_code     (i_key_code),
        .i_room         (i_room),
        .i_delays       (r_delays),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_event_key    (o_event_key),
        .o_event_pressed(o_event_pressed),
        .o_last         (o_last),
        .o_key_down     (o_key_down)
    );

`include "key_event_injector_queue_assert.svh"

    // A poll still owes words while a non-final word waits, so no input is taken.
    `KEIQ_ASSERT_IMP(a_mid_poll_stalls, o_out_valid && !o_last, o_in_stall)
    // Only a query answers with a latched key, and it is a final release-coded word.
    `KEIQ_ASSERT_IMP(a_query_shape, o_out_valid && o_key_down, o_last && !o_event_pressed)
    // After it is taken, a press updates the latch in S_PRESS, so the input waits.
    `KEIQ_ASSERT_NXT(a_press_busy,
        i_in_valid && !o_in_stall && (i_func == F_PRESS), o_in_stall)
    // A reset word starts the latch sweep, which blocks the input.
    `KEIQ_ASSERT_NXT(a_reset_sweeps,
        i_in_valid && !o_in_stall && (i_func == F_RESET), o_in_stall)

endmodule

`default_nettype wire

### verif/tb_top.sv
`default_nettype none

module tb_top;
    import kei_pkg::*;

    // Function codes without a meaning; the block must ignore them.
    localparam logic [2:0] FUNC_SPARE_A = 3'd6;
    localparam logic [2:0] FUNC_SPARE_B = 3'd7;
    localparam int PEND_MAX   = 16;
    localparam int DEFR_MAX   = 16;
    localparam int SETTLE_CYC = 400;

    typedef struct {
        logic [2:0] func;
        logic [7:0] key;
        logic [6:0] room;
    } t_word;

    typedef struct {
        logic [7:0] key;
        logic       pressed;
        logic       last;
        logic       down;
    } t_event;

    typedef struct {
        logic [7:0] key;
        logic [3:0] dly;
    } t_parked;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_func;
    logic [7:0]  i_key_code;
    logic [6:0]  i_room;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_event_key;
    logic        o_event_pressed;
    logic        o_last;
    logic        o_key_down;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    key_event_injector_queue dut (.*);

    // Stimulus, predicted state and bookkeeping.
    t_word    word_q[$];
    t_word    cur_word;
    t_event   expected_events[$];
    logic [8:0] pend_events[$];
    t_parked  parked_releases[$];
    logic [255:0] latched;
    t_delays  delay_cfg;
    int       cyc;
    int       hold_left;
    logic     hold_done = 1'b0;
    int       errors;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // A stretch of the run in which neither side idles.
    function automatic logic quiet();
        return cyc >= 1500 && cyc < 3500;
    endfunction

    function automatic logic [3:0] delay_of(logic [7:0] key);
        logic [3:0] d;
        d = '0;
        if (key == KEY_ACTIVATE) d = delay_cfg[REG_ACTIVATE];
        if (key == KEY_SNEAK)    d = delay_cfg[REG_SNEAK];
        if (key == KEY_SPRINT)   d = delay_cfg[REG_SPRINT];
        if (key == KEY_JUMP)     d = delay_cfg[REG_JUMP];
        return d;
    endfunction

    // Both lists drop their oldest entry when full.
    function automatic void queue_event(logic [7:0] key, logic pressed);
        if (pend_events.size() >= PEND_MAX) void'(pend_events.pop_front());
        pend_events.push_back({pressed, key});
    endfunction

    function automatic void park_release(logic [7:0] key, logic [3:0] d);
        t_parked p;
        if (parked_releases.size() >= DEFR_MAX) void'(parked_releases.pop_front());
        p.key = key;
        p.dly = d;
        parked_releases.push_back(p);
    endfunction

    // Count down parked releases; expired ones move to the event queue if it has room.
    function automatic void age_parked();
        t_parked kept[$];
        t_parked p;
        foreach (parked_releases[i]) begin
            p = parked_releases[i];
            if (p.dly != 0) begin
                p.dly = p.dly - 4'd1;
                kept.push_back(p);
            end else if (pend_events.size() < PEND_MAX) begin
                pend_events.push_back({1'b0, p.key});
            end else begin
                kept.push_back(p);
            end
        end
        parked_releases = kept;
    endfunction

    // Predict the events that one accepted word delivers.
    function automatic void model_word(t_word w);
        t_event ev;
        logic [8:0] e;
        int n;
        case (w.func)
            F_PRESS: begin
                if (!latched[w.key]) begin
                    queue_event(w.key, 1'b1);
                    latched[w.key] = 1'b1;
                end
            end
            F_RELEASE: begin
                if (latched[w.key]) begin
                    if (delay_of(w.key) != 0) begin
                        park_release(w.key, delay_of(w.key));
                    end else begin
                        queue_event(w.key, 1'b0);
                        latched[w.key] = 1'b0;
                    end
                end
            end
            F_PULSE: begin
                queue_event(w.key, 1'b1);
                park_release(w.key, delay_of(w.key));
                latched[w.key] = 1'b1;
            end
            F_RESET: begin
                pend_events.delete();
                parked_releases.delete();
                for (int k = 0; k < 256; k++) begin
                    if (latched[k]) begin
                        queue_event(k[7:0], 1'b0);
                        latched[k] = 1'b0;
                    end
                end
            end
            F_POLL: begin
                n = 0;
                while (pend_events.size() != 0 && n < w.room && n < RESULT_CAP) begin
                    e = pend_events.pop_front();
                    if (!e[8]) latched[e[7:0]] = 1'b0;
                    ev.key = e[7:0];
                    ev.pressed = e[8];
                    ev.last = 1'b0;
                    ev.down = 1'b0;
                    expected_events.push_back(ev);
                    n++;
                end
                if (n != 0) expected_events[expected_events.size() - 1].last = 1'b1;
                age_parked();
            end
            F_QUERY: begin
                ev.key = w.key;
                ev.pressed = 1'b0;
                ev.last = 1'b1;
                ev.down = latched[w.key];
                expected_events.push_back(ev);
            end
            default: begin
            end
        endcase
    endfunction

    // Word driver: predicts each accepted word, then offers the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) model_word(cur_word);
            if (!i_in_valid || !o_in_stall) begin
                if (word_q.size() != 0 && (quiet() || $urandom_range(0, 99) >= 32)) begin
                    cur_word = word_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_func <= cur_word.func;
                    i_key_code <= cur_word.key;
                    i_room <= cur_word.room;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side stall, with one long hold-off while many words wait, so the block backs up.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && word_q.size() > 60) begin
            i_out_stall <= 1'b1;
            hold_left <= 600;
            hold_done <= 1'b1;
        end else begin
            i_out_stall <= !quiet() && $urandom_range(0, 99) < 32;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_event ev;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected word key=%h pressed=%b last=%b down=%b", $time,
                         o_event_key, o_event_pressed, o_last, o_key_down);
                errors++;
            end else begin
                ev = expected_events.pop_front();
                if (o_event_key !== ev.key) begin
                    $display("%0t: event_key expected %h actual %h", $time, ev.key, o_event_key);
                    errors++;
                end
                if (o_event_pressed !== ev.pressed) begin
                    $display("%0t: event_pressed expected %b actual %b", $time, ev.pressed,
                             o_event_pressed);
                    errors++;
                end
                if (o_last !== ev.last) begin
                    $display("%0t: last expected %b actual %b", $time, ev.last, o_last);
                    errors++;
                end
                if (o_key_down !== ev.down) begin
                    $display("%0t: key_down expected %b actual %b", $time, ev.down, o_key_down);
                    errors++;
                end
            end
        end
    end

    task automatic add_word(logic [2:0] func, logic [7:0] key, logic [6:0] room);
        t_word w;
        w.func = func;
        w.key = key;
        w.room = room;
        word_q.push_back(w);
    endtask

    // Keys mostly from a small set, so releases and queries hit latched keys.
    function automatic logic [7:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            case ($urandom_range(0, 3))
                0: return KEY_ACTIVATE;
                1: return KEY_SNEAK;
                2: return KEY_SPRINT;
                default: return KEY_JUMP;
            endcase
        end
        if (r < 70) return 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [6:0] pick_room();
        if ($urandom_range(0, 9) == 0) return 7'd64;
        return 7'($urandom_range(0, 20));
    endfunction

    task automatic add_random(int n);
        int made;
        int r;
        int m;
        made = 0;
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                // A burst of up to 20 presses and pulses, then a poll.
                m = $urandom_range(1, 20);
                repeat (m) add_word($urandom_range(0, 1) ? F_PULSE : F_PRESS, pick_key(), 7'd0);
                add_word(F_POLL, 8'd0, pick_room());
                made += m + 1;
            end else begin
                if (r < 32)      add_word(F_PRESS, pick_key(), 7'($urandom_range(0, 64)));
                else if (r < 52) add_word(F_RELEASE, pick_key(), 7'($urandom_range(0, 64)));
                else if (r < 58) add_word(F_PULSE, pick_key(), 7'($urandom_range(0, 64)));
                else if (r < 60) add_word(F_RESET, 8'($urandom_range(0, 255)), 7'd0);
                else if (r < 85) add_word(F_POLL, 8'($urandom_range(0, 255)), pick_room());
                else if (r < 98) add_word(F_QUERY, pick_key(), 7'($urandom_range(0, 64)));
                else add_word($urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B,
                              pick_key(), 7'd0);
                made++;
            end
        end
    endtask

    // Wait until every word is taken and every event has arrived, then let work settle.
    task automatic drain();
        while (word_q.size() != 0 || i_in_valid || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {28'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        delay_cfg[idx] = v;
    endtask

    task automatic write_delays(logic [3:0] a, logic [3:0] s, logic [3:0] p, logic [3:0] j);
        write_reg(REG_ACTIVATE, a);
        write_reg(REG_SNEAK, s);
        write_reg(REG_SPRINT, p);
        write_reg(REG_JUMP, j);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_func = F_PRESS;
        i_key_code = '0;
        i_room = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cyc = 0;
        hold_left = 0;
        errors = 0;
        latched = '0;
        delay_cfg[REG_ACTIVATE] = 4'd2;
        delay_cfg[REG_SNEAK] = 4'd1;
        delay_cfg[REG_SPRINT] = 4'd4;
        delay_cfg[REG_JUMP] = 4'd1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: edges of the key range, ignored words and every function.
        write_delays(4'd3, 4'd0, 4'd15, 4'd1);
        add_word(F_QUERY, 8'h00, 7'd0);
        add_word(F_PRESS, 8'h00, 7'd0);
        add_word(F_PRESS, 8'hFF, 7'd127 & 7'd64);
        add_word(F_PRESS, 8'hFF, 7'd0);
        add_word(F_QUERY, 8'hFF, 7'd0);
        add_word(F_RELEASE, KEY_ACTIVATE, 7'd0);
        add_word(F_PRESS, KEY_ACTIVATE, 7'd0);
        add_word(F_RELEASE, KEY_ACTIVATE, 7'd0);
        add_word(F_PRESS, KEY_SNEAK, 7'd0);
        add_word(F_RELEASE, KEY_SNEAK, 7'd0);
        add_word(F_PULSE, KEY_SPRINT, 7'd0);
        add_word(F_PULSE, 8'h41, 7'd0);
        add_word(F_POLL, 8'h00, 7'd0);
        add_word(F_POLL, 8'h00, 7'd2);
        add_word(F_POLL, 8'h00, 7'd64);
        add_word(FUNC_SPARE_A, 8'h00, 7'd0);
        add_word(FUNC_SPARE_B, 8'hFF, 7'd64);
        add_word(F_QUERY, KEY_SPRINT, 7'd0);
        add_word(F_RESET, 8'h00, 7'd0);
        add_word(F_POLL, 8'hFF, 7'd64);
        add_word(F_POLL, 8'h00, 7'd64);
        add_word(F_QUERY, 8'h00, 7'd0);
        drain();

        write_delays(4'd0, 4'd0, 4'd0, 4'd0);
        add_random(90);
        drain();
        write_delays(4'd15, 4'd15, 4'd15, 4'd15);
        add_random(90);
        drain();
        write_delays(4'd2, 4'd1, 4'd4, 4'd1);
        add_random(90);
        drain();
        write_delays(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        add_random(80);
        drain();

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Give up if the run stalls.
    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/kei_pkg.sv
rtl/kei_ram.sv
rtl/kei_ctrl.sv
rtl/kei_dp.sv
rtl/key_event_injector_queue.sv
verif/tb_top.sv
